@@ rtl/txcon_pkg.sv @@
// ----------------------------------------------------------------------------
// txcon_pkg
// shared constants, types and the follow-byte glyph map of the text console
// ----------------------------------------------------------------------------
package txcon_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CELL_AW = $clog2(CELLS);
    localparam int OUT_IDX_W = 11;
    localparam int CELL_W  = 16;
    localparam int TDATA_W = 40;

    localparam logic [CELL_AW-1:0] LAST_ROW_START = CELL_AW'(CELLS - COLUMNS);

    localparam logic [7:0] LEAD_BYTE   = 8'hC3;
    localparam logic [7:0] NEWLINE     = 8'h0A;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] UNKNOWN_CHAR = 8'h3F;
    localparam logic [7:0] COLOR_RESET = 8'h0F;

    typedef struct packed {
        logic                en;
        logic [CELL_AW-1:0]  addr;
        logic [CELL_W-1:0]   data;
    } cell_wr_t;

    function automatic logic [7:0] map_follow_byte(input logic [7:0] b);
        logic [7:0] g;
        case (b)
            8'hA9:   g = 8'h82;
            8'hA8:   g = 8'h8A;
            8'hA0:   g = 8'h85;
            8'hA2:   g = 8'h83;
            8'hA7:   g = 8'h87;
            8'hAA:   g = 8'h88;
            8'hAB:   g = 8'h89;
            8'hAF:   g = 8'h8F;
            default: g = UNKNOWN_CHAR;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/txcon_screen_ram.sv @@
// ----------------------------------------------------------------------------
// txcon_screen_ram
// screen cell memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module txcon_screen_ram
    import txcon_pkg::*;
(
    input  logic                aclk,
    input  cell_wr_t            wr,
    input  logic [CELL_AW-1:0]  rd_addr,
    output logic [CELL_W-1:0]   rd_data
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/txcon_scroll_engine.sv @@
// ----------------------------------------------------------------------------
// txcon_scroll_engine
// sequencer around one shared address adder: clears the screen after reset,
// scrolls it up one row and blanks the bottom row, passes cell writes when idle
// ----------------------------------------------------------------------------
module txcon_scroll_engine
    import txcon_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start_scroll,
    input  logic [7:0]          text_color,
    input  cell_wr_t            char_wr,
    output logic                busy,
    output cell_wr_t            ram_wr,
    output logic [CELL_AW-1:0]  ram_rd_addr,
    input  logic [CELL_W-1:0]   ram_rd_data
);

    typedef enum logic [4:0] {
        E_CLEAR   = 5'b00001,
        E_IDLE    = 5'b00010,
        E_COPY_RD = 5'b00100,
        E_COPY_WR = 5'b01000,
        E_FILL    = 5'b10000
    } eng_state_t;

    eng_state_t         state_reg, state_next;
    logic [CELL_AW-1:0] cnt_reg, cnt_next;
    logic [CELL_AW-1:0] sum;
    logic [CELL_AW-1:0] addend;

    // shared address adder
    always_comb begin
        addend = (state_reg == E_COPY_RD) ? CELL_AW'(COLUMNS) : CELL_AW'(1);
        sum    = cnt_reg + addend;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ram_wr      = char_wr;
        ram_rd_addr = sum;
        case (state_reg)
            E_CLEAR: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = cnt_reg;
                ram_wr.data = {COLOR_RESET, SPACE_CHAR};
                if (cnt_reg == CELL_AW'(CELLS - 1)) begin
                    cnt_next   = '0;
                    state_next = E_IDLE;
                end else begin
                    cnt_next = sum;
                end
            end
            E_IDLE: begin
                if (start_scroll) begin
                    cnt_next   = '0;
                    state_next = E_COPY_RD;
                end
            end
            E_COPY_RD: begin
                ram_wr.en  = 1'b0;
                state_next = E_COPY_WR;
            end
            E_COPY_WR: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = cnt_reg;
                ram_wr.data = ram_rd_data;
                cnt_next    = sum;
                if (cnt_reg == CELL_AW'(CELLS - COLUMNS - 1)) begin
                    state_next = E_FILL;
                end else begin
                    state_next = E_COPY_RD;
                end
            end
            E_FILL: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = cnt_reg;
                ram_wr.data = {text_color, SPACE_CHAR};
                if (cnt_reg == CELL_AW'(CELLS - 1)) begin
                    cnt_next   = '0;
                    state_next = E_IDLE;
                end else begin
                    cnt_next = sum;
                end
            end
            default: begin
                cnt_next   = '0;
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != E_IDLE);

endmodule

@@ rtl/text_console_char_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// text console writer: cursor tracking, utf-8 lead handling, cell writes and
// scrolling of an 80 x 25 screen held in on-chip memory
//
//   channel   direction  handshake            payload
//   s_        in         s_tvalid/s_tready    s_tdata[7:0] char_byte
//   m_        out        m_tvalid/m_tready    m_tdata[39:0] result fields
//   cfg_      in         cfg_valid/cfg_ready  cfg_data[7:0] text_color
//
// one byte per cycle while no scroll is needed and no result waits on m_tready;
// a byte that scrolls the screen holds off input until the scroll engine has
// copied each row up, with a read state and a write state per cell, and blanked the bottom row
// after reset a clearing pass over all CELLS cells runs before input is taken
// a result waiting on m_tready holds off input; a byte is taken in the cycle it leaves
// ----------------------------------------------------------------------------
module text_console_char_writer_core
    import txcon_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] char_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,    // [0] cell_written, [11:1] cell_index,
                                           // [27:12] cell_value, [28] scrolled,
                                           // [39:29] cursor_position
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data    // [7:0] text_color
);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [CELL_AW-1:0] pos_reg, pos_next;
    logic [CELL_AW-1:0] base_reg, base_next;
    logic               pend_reg, pend_next;
    logic [7:0]         color_reg;
    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;

    logic               eng_busy;
    cell_wr_t           char_wr;
    cell_wr_t           ram_wr;
    logic [CELL_AW-1:0] ram_rd_addr;
    logic [CELL_W-1:0]  ram_rd_data;

    logic               accept;
    logic               is_lead;
    logic [7:0]         glyph;
    logic               written;
    logic               scroll_now;
    logic [CELL_W-1:0]  cell_val;
    logic [TDATA_W-1:0] result;

    assign s_tready  = !eng_busy && (!m_tvalid_reg || m_tready);
    assign cfg_ready = !eng_busy;
    assign accept    = s_tvalid && s_tready;
    assign is_lead   = (s_tdata == LEAD_BYTE);

    always_comb begin
        glyph      = pend_reg ? map_follow_byte(s_tdata) : s_tdata;
        written    = (glyph != NEWLINE);
        cell_val   = {color_reg, glyph};
        col_next   = col_reg;
        row_next   = row_reg;
        pos_next   = pos_reg;
        base_next  = base_reg;
        pend_next  = pend_reg;
        scroll_now = 1'b0;
        char_wr    = '{en: 1'b0, addr: pos_reg, data: cell_val};
        if (accept) begin
            if (is_lead) begin
                pend_next = 1'b1;
            end else begin
                pend_next  = 1'b0;
                char_wr.en = written;
                if (written && (col_reg != COL_W'(COLUMNS - 1))) begin
                    col_next = col_reg + COL_W'(1);
                    pos_next = pos_reg + CELL_AW'(1);
                end else begin
                    col_next = '0;
                    if (row_reg == ROW_W'(ROWS - 1)) begin
                        scroll_now = 1'b1;
                        pos_next   = LAST_ROW_START;
                        base_next  = LAST_ROW_START;
                    end else begin
                        row_next  = row_reg + ROW_W'(1);
                        base_next = base_reg + CELL_AW'(COLUMNS);
                        pos_next  = base_reg + CELL_AW'(COLUMNS);
                    end
                end
            end
        end
        result = {OUT_IDX_W'(pos_next),
                  scroll_now,
                  written ? cell_val : CELL_W'(0),
                  written ? OUT_IDX_W'(pos_reg) : OUT_IDX_W'(0),
                  written};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            pos_reg      <= '0;
            base_reg     <= '0;
            pend_reg     <= 1'b0;
            color_reg    <= COLOR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pos_reg  <= pos_next;
            base_reg <= base_next;
            pend_reg <= pend_next;
            if (cfg_valid && cfg_ready) begin
                color_reg <= cfg_data;
            end
            if (accept && !is_lead) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !is_lead) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    txcon_scroll_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_scroll (scroll_now),
        .text_color   (color_reg),
        .char_wr      (char_wr),
        .busy         (eng_busy),
        .ram_wr       (ram_wr),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    txcon_screen_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef NO_ASSERTIONS
    a_scroll_starts_engine: assert property (@(posedge aclk) disable iff (!aresetn)
        scroll_now |=> eng_busy)
        else $error("scroll did not start the engine");

    a_scroll_cursor_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[28]) |-> (m_tdata_reg[39:29] == OUT_IDX_W'(LAST_ROW_START)))
        else $error("scrolled result with cursor off the last row start");

    a_cursor_linear: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == CELL_AW'(base_reg + CELL_AW'(col_reg)))
        else $error("linear cursor out of step with column");

    a_newline_empty_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[0]) |-> (m_tdata_reg[27:1] == '0))
        else $error("newline result carries a cell");
`endif

endmodule
